>>> hdl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define ASSERT_PROP_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/qkd_pkg.sv
`default_nettype none
package qkd_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam int POS_OUT_WIDTH  = 16;
   localparam int STEP_WIDTH     = 8;
   localparam int BOUND_WIDTH    = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   // wide enough for position plus step and for the 16 bit bounds
   localparam int SUM_WIDTH =
      ((POSITION_WIDTH > BOUND_WIDTH) ? POSITION_WIDTH : BOUND_WIDTH) + 2;

   localparam logic signed [SUM_WIDTH-1:0] POS_MAX =
      SUM_WIDTH'((64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_WIDTH-1:0] POS_MIN = -POS_MAX - SUM_WIDTH'(1);

   localparam logic signed [STEP_WIDTH-1:0]  STEP_RESET    = STEP_WIDTH'(1);
   localparam logic signed [BOUND_WIDTH-1:0] FLOOR_RESET   = BOUND_WIDTH'(0);
   localparam logic signed [BOUND_WIDTH-1:0] CEILING_RESET = BOUND_WIDTH'(16);
   localparam logic signed [BOUND_WIDTH-1:0] START_RESET   = BOUND_WIDTH'(0);

   localparam logic signed [STEP_WIDTH-1:0] STEP_MOST_NEG =
      {1'b1, {(STEP_WIDTH-1){1'b0}}};
   localparam logic signed [STEP_WIDTH-1:0] STEP_MOST_POS =
      {1'b0, {(STEP_WIDTH-1){1'b1}}};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_STEP_SIZE        = 2'd0,
      CSR_POSITION_FLOOR   = 2'd1,
      CSR_POSITION_CEILING = 2'd2,
      CSR_START_POSITION   = 2'd3
   } csr_index_type;

   // {prev B, prev A, B, A}
   localparam logic [3:0] CODE_DBL_0 = 4'b0011;
   localparam logic [3:0] CODE_DBL_1 = 4'b0110;
   localparam logic [3:0] CODE_DBL_2 = 4'b1001;
   localparam logic [3:0] CODE_DBL_3 = 4'b1100;
   localparam logic [3:0] CODE_DEC_0 = 4'b0001;
   localparam logic [3:0] CODE_DEC_1 = 4'b0111;
   localparam logic [3:0] CODE_DEC_2 = 4'b1000;
   localparam logic [3:0] CODE_DEC_3 = 4'b1110;
   localparam logic [3:0] CODE_INC_0 = 4'b0010;
   localparam logic [3:0] CODE_INC_1 = 4'b0100;
   localparam logic [3:0] CODE_INC_2 = 4'b1011;
   localparam logic [3:0] CODE_INC_3 = 4'b1101;

   typedef enum logic [1:0] {
      MOVE_NONE,
      MOVE_INC,
      MOVE_DEC,
      MOVE_DOUBLE
   } move_type;

   function automatic move_type classify(input logic [3:0] code);
      move_type m;
      case (code)
         CODE_DBL_0, CODE_DBL_1, CODE_DBL_2, CODE_DBL_3: m = MOVE_DOUBLE;
         CODE_DEC_0, CODE_DEC_1, CODE_DEC_2, CODE_DEC_3: m = MOVE_DEC;
         CODE_INC_0, CODE_INC_1, CODE_INC_2, CODE_INC_3: m = MOVE_INC;
         default: m = MOVE_NONE;
      endcase
      return m;
   endfunction

   function automatic logic signed [POSITION_WIDTH-1:0] fit_pos(
      input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0] r;
      if (v > POS_MAX) begin
         r = POS_MAX;
      end else if (v < POS_MIN) begin
         r = POS_MIN;
      end else begin
         r = v;
      end
      return r[POSITION_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

>>> hdl/qkd_req_if.sv
`default_nettype none
interface qkd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] phase_bits;
   logic       button_raw;

   modport source (output valid, output phase_bits, output button_raw, input ready);
   modport sink   (input valid, input phase_bits, input button_raw, output ready);
endinterface
`default_nettype wire

>>> hdl/qkd_rsp_if.sv
`default_nettype none
interface qkd_rsp_if;
   import qkd_pkg::*;
   logic                             valid;
   logic                             ready;
   logic signed [POS_OUT_WIDTH-1:0]  position;
   logic                             button_pressed;

   modport source (output valid, output position, output button_pressed, input ready);
   modport sink   (input valid, input position, input button_pressed, output ready);
endinterface
`default_nettype wire

>>> hdl/quadrature_knob_decoder.sv
// channel   dir  beat                          handshake
// req_chan  in   phase_bits[1:0], button_raw   valid/ready
// rsp_chan  out  position[15:0], button_pressed valid/ready
// csr       in   csr_index[1:0], csr_write_data write enable only
//
// One result beat per request beat; a beat is taken every cycle while the
// result register is empty or being drained, so the rate is one per cycle.
// Decode, add and clamp sit before the result register; the result is valid in the next cycle.
// Synchronous reset empties the result register and presets the state.
// A stalled result blocks new requests only while it is still held.
`default_nettype none
module quadrature_knob_decoder (
   input  wire                                   clock,
   input  wire                                   reset,
   qkd_req_if.sink                               req_chan,
   qkd_rsp_if.source                             rsp_chan,
   input  wire                                   csr_write_enable,
   input  wire [qkd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire [qkd_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import qkd_pkg::*;

   logic signed [STEP_WIDTH-1:0]     step_ff, step_in;
   logic signed [BOUND_WIDTH-1:0]    floor_ff, floor_in;
   logic signed [BOUND_WIDTH-1:0]    ceiling_ff, ceiling_in;
   logic [1:0]                       last_phase_ff, last_phase_in;
   logic signed [STEP_WIDTH-1:0]     last_delta_ff, last_delta_in;
   logic signed [POSITION_WIDTH-1:0] position_ff, position_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [POS_OUT_WIDTH-1:0]  rsp_position_ff, rsp_position_in;
   logic                             rsp_pressed_ff, rsp_pressed_in;

   logic                             accept;
   move_type                         move;
   logic signed [STEP_WIDTH-1:0]     step_neg;
   logic signed [STEP_WIDTH-1:0]     delta;
   logic signed [SUM_WIDTH-1:0]      sum;
   logic signed [SUM_WIDTH-1:0]      clamped;
   logic signed [SUM_WIDTH-1:0]      ceiling_ext;
   logic signed [SUM_WIDTH-1:0]      floor_ext;
   logic signed [SUM_WIDTH-1:0]      new_pos_ext;
   logic signed [POSITION_WIDTH-1:0] new_pos;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      move = classify({last_phase_ff, req_chan.phase_bits});
      step_neg = (step_ff == STEP_MOST_NEG) ? STEP_MOST_POS : -step_ff;
      case (move)
         MOVE_INC:    delta = step_ff;
         MOVE_DEC:    delta = step_neg;
         MOVE_DOUBLE: delta = last_delta_ff;
         default:     delta = last_delta_ff;
      endcase
      sum = SUM_WIDTH'(position_ff) + SUM_WIDTH'(delta);
      ceiling_ext = SUM_WIDTH'(ceiling_ff);
      floor_ext   = SUM_WIDTH'(floor_ff);
      if (sum >= ceiling_ext) begin
         clamped = ceiling_ext;
      end else if (sum <= floor_ext) begin
         clamped = floor_ext;
      end else begin
         clamped = sum;
      end
      new_pos = (move == MOVE_NONE) ? position_ff : fit_pos(clamped);
      new_pos_ext = SUM_WIDTH'(new_pos);
   end

   always_comb begin
      step_in       = step_ff;
      floor_in      = floor_ff;
      ceiling_in    = ceiling_ff;
      last_phase_in = last_phase_ff;
      last_delta_in = last_delta_ff;
      position_in   = position_ff;
      if (accept) begin
         last_phase_in = req_chan.phase_bits;
         last_delta_in = delta;
         position_in   = new_pos;
      end
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_SIZE:        step_in    = csr_write_data[STEP_WIDTH-1:0];
            CSR_POSITION_FLOOR:   floor_in   = csr_write_data[BOUND_WIDTH-1:0];
            CSR_POSITION_CEILING: ceiling_in = csr_write_data[BOUND_WIDTH-1:0];
            CSR_START_POSITION:
               position_in = fit_pos(SUM_WIDTH'($signed(csr_write_data[BOUND_WIDTH-1:0])));
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_position_in = rsp_position_ff;
      rsp_pressed_in  = rsp_pressed_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in    = 1'b1;
         rsp_position_in = new_pos_ext[POS_OUT_WIDTH-1:0];
         rsp_pressed_in  = req_chan.button_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_RESET;
         floor_ff      <= FLOOR_RESET;
         ceiling_ff    <= CEILING_RESET;
         last_phase_ff <= 2'b00;
         last_delta_ff <= '0;
         position_ff   <= fit_pos(SUM_WIDTH'(START_RESET));
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         floor_ff      <= floor_in;
         ceiling_ff    <= ceiling_in;
         last_phase_ff <= last_phase_in;
         last_delta_ff <= last_delta_in;
         position_ff   <= position_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_position_ff <= rsp_position_in;
      rsp_pressed_ff  <= rsp_pressed_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.position       = rsp_position_ff;
   assign rsp_chan.button_pressed = rsp_pressed_ff;

endmodule
`default_nettype wire

>>> hdl/qkd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module qkd_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire                                req_button_raw,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [qkd_pkg::POS_OUT_WIDTH-1:0]   rsp_position,
   input wire                                rsp_button_pressed
);
   import qkd_pkg::*;

   `ASSERT_PROP_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result beat after reset")
   `ASSERT_PROP(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "stalled while empty")
   `ASSERT_PROP(a_accept_gives_result, clock, reset, (req_valid && req_ready) |=> rsp_valid, "beat lost")
   `ASSERT_PROP(a_button_follows, clock, reset, (req_valid && req_ready) |=> (rsp_button_pressed == $past(req_button_raw)), "button flag wrong")
   `ASSERT_PROP(a_stall_holds, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position) && $stable(rsp_button_pressed)), "held beat changed")

endmodule

bind quadrature_knob_decoder qkd_checker u_qkd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_button_raw     (req_chan.button_raw),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_position       (rsp_chan.position),
   .rsp_button_pressed (rsp_chan.button_pressed)
);
`default_nettype wire
